// ----- rtl/stq_pkg.sv -----
// Shared types, constants and the node combine function of the segment tree block.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
  localparam int NODE_AW     = IDX_BITS + 1;
  localparam int PTR_BITS    = IDX_BITS + 2;
  localparam int SIZE_BITS   = 11;
  localparam int MODE_BITS   = 2;
  localparam int OUT_BITS    = 32;

  localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SUM = 2'd2;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_REBUILD,
    ST_IDLE,
    ST_UPDATE,
    ST_QUERY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]   idx;
    logic [VALUE_BITS-1:0] val;
  } node_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] wa;
    node_t              wd;
    logic [NODE_AW-1:0] ra;
    logic [NODE_AW-1:0] rb;
  } ram_req_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] answer;
    logic                empty_res;
    logic                rejected;
  } res_t;

  function automatic node_t node_merge(input logic [MODE_BITS-1:0] md,
                                       input node_t a, input node_t b);
    node_t r;
    logic  lt;
    logic  eq;
    r  = a;
    lt = $signed(a.val) < $signed(b.val);
    eq = a.val == b.val;
    if (md >= MODE_SUM) begin
      r.val = a.val + b.val;
    end else if (eq) begin
      r = (a.idx <= b.idx) ? a : b;
    end else if (md == MODE_MIN) begin
      r = lt ? a : b;
    end else begin
      r = lt ? b : a;
    end
    return r;
  endfunction

endpackage

// ----- rtl/segment_tree_range_query_top.sv -----
// Top level of the segment tree range query block: memory, sequencer, output register.
`timescale 1ns / 1ps
// Input channel in_valid/in_ready carries opcode, index_lo, index_hi, new_value.
// Opcode update writes new_value at index_lo and repairs the path to the root;
// opcode query returns min index, max index or wrapping sum over the clipped
// range, as chosen by the mode register. Output channel out_valid/out_ready
// carries answer, empty_res and rejected, one result per transfer in.
// Configuration: cfg_we with cfg_index (0 mode, 1 active_size) and cfg_data.
// A mode write starts a rebuild of all 1023 inner nodes, during which
// no item is taken.
// An update walks the path to the root and a query the tree levels that the
// clipped range spans, one level per cycle against the node memory.
// Items are handled one at a time; the next item is taken while a result
// waits in the output register, and a stalled receiver holds the block in
// its finishing state until the register drains.
// After reset the block writes the 1024 leaves and then builds the inner
// nodes before in_ready rises.
module segment_tree_range_query_top import stq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [IDX_BITS-1:0]          index_lo,
  input  logic [IDX_BITS-1:0]          index_hi,
  input  logic signed [VALUE_BITS-1:0] new_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_BITS-1:0]   answer,
  output logic                         empty_res,
  output logic                         rejected,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [SIZE_BITS-1:0]         cfg_data
);

  ram_req_t ram_req;
  node_t    rda, rdb;
  logic     res_valid;
  res_t     res;
  logic     out_free;

  assign out_free = !out_valid || out_ready;

  stq_ram #(
    .WIDTH($bits(node_t)),
    .AW   (NODE_AW)
  ) u_ram (
    .clk(clk),
    .we (ram_req.we),
    .wa (ram_req.wa),
    .wd (ram_req.wd),
    .ra (ram_req.ra),
    .rb (ram_req.rb),
    .qa (rda),
    .qb (rdb)
  );

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .index_lo (index_lo),
    .index_hi (index_hi),
    .new_value(new_value),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_free (out_free),
    .res_valid(res_valid),
    .res_out  (res),
    .ram_req  (ram_req),
    .rda      (rda),
    .rdb      (rdb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      answer    <= res.answer;
      empty_res <= res.empty_res;
      rejected  <= res.rejected;
    end
  end

endmodule

// ----- rtl/stq_ram.sv -----
// Two-read, one-write synchronous RAM with write-first forwarding.
`timescale 1ns / 1ps
module stq_ram #(
  parameter int WIDTH = 42,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  input  logic [AW-1:0]    rb,
  output logic [WIDTH-1:0] qa,
  output logic [WIDTH-1:0] qb
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= (we && wa == ra) ? wd : mem[ra];
    qb <= (we && wa == rb) ? wd : mem[rb];
  end

endmodule

// ----- rtl/stq_ctrl.sv -----
// Sequencer for clearing, rebuilding, updating and querying the tree memory.
`timescale 1ns / 1ps
module stq_ctrl import stq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [IDX_BITS-1:0]   index_lo,
  input  logic [IDX_BITS-1:0]   index_hi,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SIZE_BITS-1:0]  cfg_data,
  input  logic                  out_free,
  output logic                  res_valid,
  output res_t                  res_out,
  output ram_req_t              ram_req,
  input  node_t                 rda,
  input  node_t                 rdb
);

  state_t               state, state_next;
  logic [MODE_BITS-1:0] mode;
  logic [SIZE_BITS-1:0] active_size;
  logic                 pend, pend_next;
  logic [IDX_BITS-1:0]  cnt, cnt_next;
  logic                 wv, wv_next;
  logic [IDX_BITS-1:0]  wp, wp_next;
  logic [NODE_AW-1:0]   cur, cur_next;
  node_t                carry, carry_next;
  logic [PTR_BITS-1:0]  l, l_next, r, r_next;
  logic                 s1_tl, s1_tl_next, s1_tr, s1_tr_next;
  logic                 s2_mv, s2_mv_next;
  node_t                m, m_next;
  node_t                acc, acc_next;
  logic                 has, has_next;
  res_t                 res, res_next;

  logic                 mode_wr;
  logic [SIZE_BITS-1:0] size_eff;
  logic [SIZE_BITS-1:0] lo_ext, hi_ext, hi_c;
  logic                 q_empty;
  logic [NODE_AW-1:0]   par;
  logic [PTR_BITS-1:0]  r_dec;
  node_t                mg;

  assign mode_wr  = cfg_we && cfg_index == CFG_MODE;
  assign size_eff = (active_size > SIZE_BITS'(MAX_ENTRIES)) ? SIZE_BITS'(MAX_ENTRIES)
                                                           : active_size;
  assign lo_ext   = {1'b0, index_lo};
  assign hi_ext   = {1'b0, index_hi};
  assign q_empty  = size_eff == '0 || lo_ext >= size_eff || index_lo > index_hi;
  assign hi_c     = (hi_ext >= size_eff) ? size_eff - SIZE_BITS'(1) : hi_ext;
  assign par      = {1'b0, cur[NODE_AW-1:1]};
  assign r_dec    = r - PTR_BITS'(1);
  assign mg       = node_merge(mode, carry, rda);
  assign res_out  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      mode        <= MODE_SUM;
      active_size <= SIZE_BITS'(MAX_ENTRIES);
      pend        <= 1'b0;
      cnt         <= '0;
      wv          <= 1'b0;
      s1_tl       <= 1'b0;
      s1_tr       <= 1'b0;
      s2_mv       <= 1'b0;
      has         <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      cnt   <= cnt_next;
      wv    <= wv_next;
      s1_tl <= s1_tl_next;
      s1_tr <= s1_tr_next;
      s2_mv <= s2_mv_next;
      has   <= has_next;
      if (cfg_we) begin
        if (cfg_index == CFG_MODE) begin
          mode <= cfg_data[MODE_BITS-1:0];
        end else begin
          active_size <= cfg_data;
        end
      end
    end
    wp    <= wp_next;
    cur   <= cur_next;
    carry <= carry_next;
    l     <= l_next;
    r     <= r_next;
    m     <= m_next;
    acc   <= acc_next;
    res   <= res_next;
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cnt_next   = cnt;
    wv_next    = wv;
    wp_next    = wp;
    cur_next   = cur;
    carry_next = carry;
    l_next     = l;
    r_next     = r;
    s1_tl_next = s1_tl;
    s1_tr_next = s1_tr;
    s2_mv_next = s2_mv;
    m_next     = m;
    acc_next   = acc;
    has_next   = has;
    res_next   = res;
    ram_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        ram_req.we     = 1'b1;
        ram_req.wa     = {1'b1, cnt};
        ram_req.wd.idx = cnt;
        ram_req.wd.val = '0;
        cnt_next       = cnt + IDX_BITS'(1);
        if (cnt == '1) begin
          state_next = ST_REBUILD;
          pend_next  = 1'b0;
          cnt_next   = '1;
          wv_next    = 1'b0;
        end
      end
      ST_REBUILD: begin
        if (wv) begin
          ram_req.we = 1'b1;
          ram_req.wa = {1'b0, wp};
          ram_req.wd = node_merge(mode, rda, rdb);
        end
        if (cnt != '0) begin
          ram_req.ra = {cnt, 1'b0};
          ram_req.rb = {cnt, 1'b1};
          wp_next    = cnt;
          wv_next    = 1'b1;
          cnt_next   = cnt - IDX_BITS'(1);
        end else begin
          wv_next = 1'b0;
          if (!wv) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        in_ready = !pend && !mode_wr;
        if (pend) begin
          state_next = ST_REBUILD;
          pend_next  = 1'b0;
          cnt_next   = '1;
          wv_next    = 1'b0;
        end else if (in_valid && in_ready) begin
          res_next = '0;
          if (opcode == OP_UPDATE) begin
            if (lo_ext >= size_eff) begin
              res_next.rejected = 1'b1;
              state_next        = ST_DONE;
            end else begin
              ram_req.we     = 1'b1;
              ram_req.wa     = {1'b1, index_lo};
              ram_req.wd.idx = index_lo;
              ram_req.wd.val = new_value;
              ram_req.ra     = {1'b1, index_lo[IDX_BITS-1:1], ~index_lo[0]};
              cur_next       = {1'b1, index_lo};
              carry_next     = ram_req.wd;
              state_next     = ST_UPDATE;
            end
          end else if (q_empty) begin
            res_next.empty_res = 1'b1;
            state_next         = ST_DONE;
          end else begin
            l_next     = PTR_BITS'(MAX_ENTRIES) + PTR_BITS'(index_lo);
            r_next     = PTR_BITS'(MAX_ENTRIES) + PTR_BITS'(hi_c) + PTR_BITS'(1);
            s1_tl_next = 1'b0;
            s1_tr_next = 1'b0;
            s2_mv_next = 1'b0;
            has_next   = 1'b0;
            state_next = ST_QUERY;
          end
        end
      end
      ST_UPDATE: begin
        ram_req.we = 1'b1;
        ram_req.wa = par;
        ram_req.wd = mg;
        ram_req.ra = {par[NODE_AW-1:1], ~par[0]};
        carry_next = mg;
        cur_next   = par;
        if (par == NODE_AW'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_QUERY: begin
        if (l < r) begin
          ram_req.ra = l[NODE_AW-1:0];
          ram_req.rb = r_dec[NODE_AW-1:0];
          s1_tl_next = l[0];
          s1_tr_next = r[0];
          l_next     = (l + PTR_BITS'(l[0])) >> 1;
          r_next     = r >> 1;
        end else begin
          s1_tl_next = 1'b0;
          s1_tr_next = 1'b0;
        end
        s2_mv_next = s1_tl || s1_tr;
        if (s1_tl && s1_tr) begin
          m_next = node_merge(mode, rda, rdb);
        end else if (s1_tl) begin
          m_next = rda;
        end else begin
          m_next = rdb;
        end
        if (s2_mv) begin
          acc_next = has ? node_merge(mode, acc, m) : m;
          has_next = 1'b1;
        end
        if (!(l < r) && !s1_tl && !s1_tr && !s2_mv) begin
          res_next.answer = (mode >= MODE_SUM) ? OUT_BITS'(acc.val) : OUT_BITS'(acc.idx);
          state_next      = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (mode_wr) begin
      pend_next = 1'b1;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the segment tree range query block: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import stq_pkg::*;

  localparam int CYCLE_LIMIT = 900000;
  localparam int SETTLE      = 40;

  typedef enum logic [1:0] {ROW_UPDATE, ROW_QUERY, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] val;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         opcode = OP_UPDATE;
  logic [IDX_BITS-1:0]          index_lo = '0;
  logic [IDX_BITS-1:0]          index_hi = '0;
  logic signed [VALUE_BITS-1:0] new_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [OUT_BITS-1:0]   answer;
  logic                         empty_res;
  logic                         rejected;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = CFG_MODE;
  logic [SIZE_BITS-1:0]         cfg_data = '0;

  segment_tree_range_query_top dut (.*);

  logic signed [VALUE_BITS-1:0] shadow_vals [MAX_ENTRIES];
  logic [MODE_BITS-1:0]         shadow_mode;
  logic [SIZE_BITS-1:0]         shadow_size;
  res_t                         pending_results [$];
  stim_row_t                    directed_rows [$];
  int                           fail_count = 0;
  int unsigned                  cycle_count = 0;
  int unsigned                  send_idle_pct = 0;
  int unsigned                  recv_stall_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic res_t range_result(input logic op, input int unsigned lo,
                                        input int unsigned hi, input logic [31:0] val);
    res_t        r;
    int unsigned lim;
    int unsigned best;
    logic [31:0] total;
    lim = (shadow_size > MAX_ENTRIES) ? MAX_ENTRIES : shadow_size;
    r = '0;
    if (op == OP_UPDATE) begin
      if (lo >= lim) r.rejected = 1'b1;
      else shadow_vals[lo] = val;
      return r;
    end
    if (lim == 0 || lo >= lim || lo > hi) begin
      r.empty_res = 1'b1;
      return r;
    end
    if (hi >= lim) hi = lim - 1;
    if (shadow_mode >= MODE_SUM) begin
      total = '0;
      for (int unsigned i = lo; i <= hi; i++) total += shadow_vals[i];
      r.answer = total;
    end else begin
      best = lo;
      for (int unsigned i = lo + 1; i <= hi; i++) begin
        if (shadow_mode == MODE_MIN && shadow_vals[i] < shadow_vals[best]) best = i;
        if (shadow_mode == MODE_MAX && shadow_vals[i] > shadow_vals[best]) best = i;
      end
      r.answer = best;
    end
    return r;
  endfunction

  // drain the result store before touching configuration
  task automatic write_config(input logic idx, input logic [SIZE_BITS-1:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (!in_ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) shadow_mode = data[MODE_BITS-1:0];
    else shadow_size = data;
  endtask

  task automatic send_item(input logic op, input int unsigned lo, input int unsigned hi,
                           input logic [31:0] val, input bit typed, input res_t want);
    res_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    index_lo  <= lo[IDX_BITS-1:0];
    index_hi  <= hi[IDX_BITS-1:0];
    new_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = range_result(op, lo, hi, val);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic add_row(input row_kind_t kind, input int unsigned lo, input int unsigned hi,
                         input logic [31:0] val, input bit typed, input logic [31:0] ans,
                         input logic emp, input logic rej);
    stim_row_t row;
    row.kind = kind;
    row.lo = lo;
    row.hi = hi;
    row.val = val;
    row.typed = typed;
    row.want.answer = ans;
    row.want.empty_res = emp;
    row.want.rejected = rej;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: answer %0d", answer);
        fail_count++;
      end else begin
        res_t exp_r;
        exp_r = pending_results.pop_front();
        if (answer !== exp_r.answer) begin
          $error("answer: expected %0d, actual %0d", $signed(exp_r.answer), answer);
          fail_count++;
        end
        if (empty_res !== exp_r.empty_res) begin
          $error("empty_res: expected %0b, actual %0b", exp_r.empty_res, empty_res);
          fail_count++;
        end
        if (rejected !== exp_r.rejected) begin
          $error("rejected: expected %0b, actual %0b", exp_r.rejected, rejected);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] val;
    logic        op;
    int unsigned pick;
    for (int i = 0; i < MAX_ENTRIES; i++) shadow_vals[i] = '0;
    shadow_mode = MODE_SUM;
    shadow_size = 11'd1024;

    add_row(ROW_QUERY, 0, 1023, 0, 1, 0, 0, 0);
    add_row(ROW_UPDATE, 0, 0, 32'h7fffffff, 1, 0, 0, 0);
    add_row(ROW_UPDATE, 1023, 0, 32'h80000000, 1, 0, 0, 0);
    add_row(ROW_QUERY, 0, 1023, 0, 1, 32'hffffffff, 0, 0);
    add_row(ROW_UPDATE, 512, 0, -5, 0, 0, 0, 0);
    add_row(ROW_QUERY, 5, 3, 0, 1, 0, 1, 0);
    add_row(ROW_CONFIG, CFG_MODE, 0, MODE_MIN, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 1023, 0, 1, 1023, 0, 0);
    add_row(ROW_QUERY, 1, 511, 0, 1, 1, 0, 0);
    add_row(ROW_CONFIG, CFG_MODE, 0, MODE_MAX, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 1023, 0, 1, 0, 0, 0);
    add_row(ROW_CONFIG, CFG_MODE, 0, 3, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 1023, 0, 0, 0, 0, 0);
    add_row(ROW_CONFIG, CFG_SIZE, 0, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 0, 0, 0, 1, 0, 1, 0);
    add_row(ROW_UPDATE, 0, 0, 32'h12345678, 1, 0, 0, 1);
    add_row(ROW_CONFIG, CFG_SIZE, 0, 2047, 0, 0, 0, 0);
    add_row(ROW_QUERY, 1000, 1023, 0, 0, 0, 0, 0);
    add_row(ROW_CONFIG, CFG_SIZE, 0, 1, 0, 0, 0, 0);
    add_row(ROW_UPDATE, 1, 0, 5, 1, 0, 0, 1);
    add_row(ROW_QUERY, 0, 1023, 0, 0, 0, 0, 0);
    add_row(ROW_QUERY, 1, 1, 0, 1, 0, 1, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CONFIG)
        write_config(directed_rows[k].lo[0], directed_rows[k].val[SIZE_BITS-1:0]);
      else
        send_item(directed_rows[k].kind == ROW_QUERY ? OP_QUERY : OP_UPDATE,
                  directed_rows[k].lo, directed_rows[k].hi, directed_rows[k].val,
                  directed_rows[k].typed, directed_rows[k].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      write_config(CFG_MODE, SIZE_BITS'($urandom_range(3)));
      pick = $urandom_range(9);
      if (pick < 2) write_config(CFG_SIZE, SIZE_BITS'(1024));
      else if (pick < 6) write_config(CFG_SIZE, SIZE_BITS'($urandom_range(1, 40)));
      else if (pick < 8) write_config(CFG_SIZE, SIZE_BITS'($urandom_range(1, 2047)));
      else if (pick < 9) write_config(CFG_SIZE, SIZE_BITS'($urandom_range(1, 2)));
      else write_config(CFG_SIZE, '0);
      lim = (shadow_size > MAX_ENTRIES) ? MAX_ENTRIES : shadow_size;
      for (int n = 0; n < 125; n++) begin
        op = $urandom_range(1) ? OP_QUERY : OP_UPDATE;
        if (lim != 0 && $urandom_range(9) < 8) begin
          lo = $urandom_range(lim - 1);
          hi = $urandom_range(9) < 8 ? $urandom_range(lo, lim - 1) : $urandom_range(1023);
        end else begin
          lo = $urandom_range(1023);
          hi = $urandom_range(1023);
        end
        pick = $urandom_range(9);
        if (pick < 3) val = $urandom_range(3) - 1;
        else if (pick < 4) val = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        else val = $urandom;
        send_item(op, lo, hi, val, 0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
